/* rtl/lppd_pkg.sv */
// Shared types and constants for the length-prefixed packet deframer.
package lppd_pkg;

  localparam int COUNT_BITS = 26;
  localparam int LIM_W      = 34;
  localparam int ADDR_W     = 3;
  localparam logic [26:0] MAX_LEN_RESET = 27'd67108864;
  localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = 3'd0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ptype;
    logic [7:0]  value;
    logic        first;
    logic        last;
    logic [31:0] rejected;
  } result_t;

endpackage

/* rtl/lppd_cfg.sv */
// Configuration register file with APB-style access.
module lppd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lppd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [26:0]                 max_len
);
  import lppd_pkg::*;

  logic [26:0] max_len_r;
  logic [26:0] max_len_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_LEN);

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = pwdata[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign prdata  = (paddr == ADDR_MAX_LEN) ? {5'd0, max_len_r} : 32'd0;
  assign max_len = max_len_r;

endmodule

/* rtl/lppd_parse.sv */
// Per-byte framing state and result computation.
module lppd_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [7:0]            data_byte,
  input  logic [26:0]           max_len,
  output logic                  res_vld,
  output lppd_pkg::result_t     res
);
  import lppd_pkg::*;

  phase_t                phase_r,  phase_nxt;
  logic [1:0]            hdr_r,    hdr_nxt;
  logic [31:0]           shift_r,  shift_nxt;
  logic [COUNT_BITS-1:0] rem_r,    rem_nxt;
  logic [7:0]            type_r,   type_nxt;
  logic                  first_r,  first_nxt;
  logic [LIM_W-1:0]      cap;
  logic [LIM_W-1:0]      limit;
  logic [31:0]           len_m1;

  // Accepted maximum is capped at the counter range.
  assign cap    = LIM_W'(1) << COUNT_BITS;
  assign limit  = (LIM_W'(max_len) > cap) ? cap : LIM_W'(max_len);
  assign len_m1 = shift_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    type_nxt  = type_r;
    first_nxt = first_r;
    res_vld   = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (phase_r)
        PH_HEADER: begin
          shift_nxt = {shift_r[23:0], data_byte};
          if (hdr_r != 2'd3) begin
            hdr_nxt = hdr_r + 2'd1;
          end else begin
            hdr_nxt = 2'd0;
            if (shift_nxt == 32'd0 || LIM_W'(shift_nxt) > limit) begin
              phase_nxt    = PH_HALTED;
              res_vld      = 1'b1;
              res.kind     = KIND_BAD_LEN;
              res.rejected = shift_nxt;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          type_nxt = data_byte;
          if (shift_r == 32'd1) begin
            phase_nxt = PH_HEADER;
            res_vld   = 1'b1;
            res.kind  = KIND_EMPTY;
            res.ptype = data_byte;
            res.last  = 1'b1;
          end else begin
            rem_nxt   = len_m1[COUNT_BITS-1:0];
            first_nxt = 1'b1;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_vld   = 1'b1;
          res.kind  = KIND_PAYLOAD;
          res.ptype = type_r;
          res.value = data_byte;
          res.first = first_r;
          res.last  = (rem_r <= COUNT_BITS'(1));
          first_nxt = 1'b0;
          if (rem_r != '0) begin
            rem_nxt = rem_r - COUNT_BITS'(1);
          end
          if (rem_nxt == '0) begin
            phase_nxt = PH_HEADER;
            first_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= 2'd0;
      shift_r <= 32'd0;
      rem_r   <= '0;
      type_r  <= 8'd0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
      type_r  <= type_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

/* rtl/lppd_out_reg.sv */
// Result register between the parser and the output channel.
module lppd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              res_vld,
  input  lppd_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output lppd_pkg::result_t out_res,
  output logic              take_ok
);
  import lppd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Room for a new item when empty or when the held item leaves now.
  assign take_ok = !valid_r || out_ready;

  always_comb begin
    if (in_fire) begin
      valid_nxt = res_vld;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/length_prefixed_packet_deframer.sv */
// A result item is registered and appears in the cycle after the input byte that causes it.
// Throughput: one byte per cycle while out_ready is high or the result register
// is empty; framing state and result register update in the cycle a byte is taken.
// Reset (rst_n low, synchronous): header phase, counters cleared, result
// register empty, max_packet_length back to 2^26. No clearing pass needed.
// After a bad length the block keeps accepting bytes and drops them until reset.
module length_prefixed_packet_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  // input byte stream
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  // result stream
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [7:0]                  out_packet_type,
  output logic [7:0]                  out_payload_value,
  output logic                        out_first_of_packet,
  output logic                        out_last_of_packet,
  output logic [31:0]                 out_rejected_length,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lppd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lppd_pkg::*;

  logic        in_fire;
  logic        take_ok;
  logic        res_vld;
  logic [26:0] max_len;
  result_t     res;
  result_t     out_res;

  // An item is taken whenever the result register can absorb what it makes;
  // bytes that make no result also pass through this gate, keeping it simple.
  assign in_ready = take_ok;
  assign in_fire  = in_valid && take_ok;

  lppd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  // Header shift, length check, type capture and payload countdown.
  lppd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .max_len   (max_len),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Result register decouples the two handshakes.
  lppd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .take_ok   (take_ok)
  );

  assign out_result_kind     = out_res.kind;
  assign out_packet_type     = out_res.ptype;
  assign out_payload_value   = out_res.value;
  assign out_first_of_packet = out_res.first;
  assign out_last_of_packet  = out_res.last;
  assign out_rejected_length = out_res.rejected;

endmodule
